[sv/pfc_pkg.sv]
// shared types and constants for the byte playfair cipher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int BYTE_W   = 8;
  localparam int SIDE_DEF = 16;
  localparam int REQ_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_KEY_START  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_KEY_BYTE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_KEY_FINISH = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TEXT_BYTE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TEXT_END   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_POS,
    ST_SQ
  } state_t;

  typedef struct packed {
    logic              clear;
    logic              place_en;
    logic [BYTE_W-1:0] place_byte;
    logic              pos_rd_en;
    logic [BYTE_W-1:0] pos_addr_a;
    logic [BYTE_W-1:0] pos_addr_b;
    logic              sq_rd_en;
  } tbl_cmd_t;

endpackage

`default_nettype wire

[sv/pfc_tables.sv]
// square and inverse tables in synchronous memories, used set and fill count
// depends on pfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfc_tables #(
  parameter int SIDE = pfc_pkg::SIDE_DEF,
  localparam int CELL_W = 2 * $clog2(SIDE)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pfc_pkg::tbl_cmd_t          cmd,
  input  wire logic [CELL_W-1:0]          sq_addr_a,
  input  wire logic [CELL_W-1:0]          sq_addr_b,
  output logic [CELL_W-1:0]               pos_a,
  output logic [CELL_W-1:0]               pos_b,
  output logic [pfc_pkg::BYTE_W-1:0]      sq_a,
  output logic [pfc_pkg::BYTE_W-1:0]      sq_b
);
  import pfc_pkg::*;

  localparam int CELLS = 1 << CELL_W;
  localparam int NBYTE = 1 << BYTE_W;

  logic [BYTE_W-1:0] sq_mem  [CELLS];
  logic [CELL_W-1:0] pos_mem [NBYTE];

  logic [NBYTE-1:0]  used_r, used_nxt;
  logic [CELL_W:0]   fill_r, fill_nxt;
  logic              place_ok;

  logic [CELL_W-1:0] pos_a_r, pos_b_r;
  logic              used_a_r, used_b_r;
  logic [BYTE_W-1:0] sq_a_r, sq_b_r;
  logic              sq_ok_a_r, sq_ok_b_r;

  assign place_ok = cmd.place_en && !fill_r[CELL_W] && !used_r[cmd.place_byte];

  always_comb begin
    used_nxt = used_r;
    fill_nxt = fill_r;
    if (cmd.clear) begin
      used_nxt = '0;
      fill_nxt = '0;
    end else if (place_ok) begin
      used_nxt[cmd.place_byte] = 1'b1;
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      fill_r <= '0;
    end else begin
      used_r <= used_nxt;
      fill_r <= fill_nxt;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (place_ok && !cmd.clear) begin
      sq_mem[fill_r[CELL_W-1:0]] <= cmd.place_byte;
      pos_mem[cmd.place_byte]    <= fill_r[CELL_W-1:0];
    end
  end

  // inverse table reads, unplaced bytes sit at cell zero
  always_ff @(posedge clk) begin
    if (cmd.pos_rd_en) begin
      pos_a_r  <= pos_mem[cmd.pos_addr_a];
      pos_b_r  <= pos_mem[cmd.pos_addr_b];
      used_a_r <= used_r[cmd.pos_addr_a];
      used_b_r <= used_r[cmd.pos_addr_b];
    end
  end

  // square reads, unfilled cells read zero
  always_ff @(posedge clk) begin
    if (cmd.sq_rd_en) begin
      sq_a_r    <= sq_mem[sq_addr_a];
      sq_b_r    <= sq_mem[sq_addr_b];
      sq_ok_a_r <= ({1'b0, sq_addr_a} < fill_r);
      sq_ok_b_r <= ({1'b0, sq_addr_b} < fill_r);
    end
  end

  assign pos_a = used_a_r ? pos_a_r : '0;
  assign pos_b = used_b_r ? pos_b_r : '0;
  assign sq_a  = sq_ok_a_r ? sq_a_r : '0;
  assign sq_b  = sq_ok_b_r ? sq_b_r : '0;

endmodule

`default_nettype wire

[sv/pfc_pair_map.sv]
// playfair pair rule: maps two cell positions to the two result cells
// depends on pfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfc_pair_map #(
  parameter int SIDE = pfc_pkg::SIDE_DEF,
  localparam int SIDE_W = $clog2(SIDE),
  localparam int CELL_W = 2 * SIDE_W
) (
  input  wire logic              mode,
  input  wire logic [CELL_W-1:0] pos_a,
  input  wire logic [CELL_W-1:0] pos_b,
  output logic [CELL_W-1:0]      cell_a,
  output logic [CELL_W-1:0]      cell_b
);
  import pfc_pkg::*;

  logic [SIDE_W-1:0] ra, ca, rb, cb, step;
  logic [SIDE_W-1:0] ra_n, ca_n, rb_n, cb_n;

  always_comb begin
    ra   = pos_a[CELL_W-1:SIDE_W];
    ca   = pos_a[SIDE_W-1:0];
    rb   = pos_b[CELL_W-1:SIDE_W];
    cb   = pos_b[SIDE_W-1:0];
    // minus one modulo side when decrypting
    step = mode ? {SIDE_W{1'b1}} : SIDE_W'(1);
    ra_n = ra;
    ca_n = ca;
    rb_n = rb;
    cb_n = cb;
    if (ra == rb) begin
      ca_n = ca + step;
      cb_n = cb + step;
    end else if (ca == cb) begin
      ra_n = ra + step;
      rb_n = rb + step;
    end else begin
      ca_n = cb;
      cb_n = ca;
    end
    cell_a = {ra_n, ca_n};
    cell_b = {rb_n, cb_n};
  end

endmodule

`default_nettype wire

[sv/byte_playfair_cipher.sv]
// byte playfair cipher top level: request sequencer, pairing and result register
// depends on pfc_pkg, pfc_tables and pfc_pair_map
//
// usage: items enter on in_valid/in_stall, one transfer per edge with valid high
// and stall low. in_req_type selects key start, key byte, key finish, text byte
// or text end; in_in_byte carries the byte. results leave on out_valid/out_stall
// as a pair of bytes with kept flags and an end-of-text flag.
// mode and marker are written through cfg_wr_en/cfg_index/cfg_data. the user
// must write them only while idle; the block itself does not enforce this.
// key start and key byte do not stall the input. key finish sweeps all 256 byte
// values through the tables, one per cycle, with the input stalled throughout.
// a text byte that completes a pair, or a text end with a byte held, passes
// the inverse table read, the square read, then the result register, which
// waits while the output is stalled; the input is stalled until it is loaded.
// other text items do not stall the input.
// reset clears the used set, fill count, held byte, mode and marker; the table
// memories need no clearing pass. a stalled result stays in the output register
// while key and unpaired text items are still taken; a new pair waits for it.
`timescale 1ns / 1ps
`default_nettype none

module byte_playfair_cipher #(
  parameter int SIDE = pfc_pkg::SIDE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pfc_pkg::REQ_W-1:0]     in_req_type,
  input  wire logic [pfc_pkg::BYTE_W-1:0]    in_in_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pfc_pkg::BYTE_W-1:0]         out_first_byte,
  output logic                               out_first_kept,
  output logic [pfc_pkg::BYTE_W-1:0]         out_second_byte,
  output logic                               out_second_kept,
  output logic                               out_end_of_text,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pfc_pkg::BYTE_W-1:0]    cfg_data
);
  import pfc_pkg::*;

  localparam int CELL_W = 2 * $clog2(SIDE);

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic [BYTE_W-1:0] marker_r;
  logic [BYTE_W-1:0] held_byte_r, held_byte_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic              eot_r;
  logic [BYTE_W-1:0] sweep_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_first_r, out_second_r;
  logic              out_first_kept_r, out_second_kept_r, out_eot_r;

  logic              in_acc, pair_go, out_free, load_out;
  logic [BYTE_W-1:0] text_b;
  tbl_cmd_t          cmd;

  logic [CELL_W-1:0] pos_a, pos_b, cell_a, cell_b;
  logic [BYTE_W-1:0] sq_a, sq_b;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign text_b   = (held_byte_r == in_in_byte) ? marker_r : in_in_byte;
  assign pair_go  = in_acc && held_valid_r &&
                    (in_req_type inside {REQ_TEXT_BYTE, REQ_TEXT_END});

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      marker_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_MARKER: marker_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // pairing
  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    if (in_acc) begin
      case (in_req_type)
        REQ_KEY_START: begin
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
        end
        REQ_TEXT_BYTE: begin
          if (!held_valid_r) begin
            held_byte_nxt  = in_in_byte;
            held_valid_nxt = 1'b1;
          end else if (held_byte_r != in_in_byte) begin
            held_valid_nxt = 1'b0;
          end
        end
        REQ_TEXT_END:  held_valid_nxt = 1'b0;
        default:       ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pair_go) begin
          state_nxt = ST_POS;
        end else if (in_acc && in_req_type == REQ_KEY_FINISH) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sweep_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POS:  state_nxt = ST_SQ;
      ST_SQ: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    cmd.clear      = in_acc && (in_req_type == REQ_KEY_START);
    cmd.place_en   = (in_acc && (in_req_type == REQ_KEY_BYTE)) || (state_r == ST_FINISH);
    cmd.place_byte = (state_r == ST_FINISH) ? sweep_r : in_in_byte;
    cmd.pos_rd_en  = pair_go;
    cmd.pos_addr_a = held_byte_r;
    cmd.pos_addr_b = (in_req_type == REQ_TEXT_END) ? marker_r : text_b;
    cmd.sq_rd_en   = (state_r == ST_POS);
    load_out       = (state_r == ST_SQ) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      sweep_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      if (state_r == ST_FINISH) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_go) begin
      eot_r <= (in_req_type == REQ_TEXT_END);
    end
    if (load_out) begin
      out_first_r       <= sq_a;
      out_second_r      <= sq_b;
      out_first_kept_r  <= !(mode_r && sq_a == marker_r);
      out_second_kept_r <= !(mode_r && sq_b == marker_r);
      out_eot_r         <= eot_r;
    end
  end

  pfc_tables #(.SIDE(SIDE)) u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sq_addr_a (cell_a),
    .sq_addr_b (cell_b),
    .pos_a     (pos_a),
    .pos_b     (pos_b),
    .sq_a      (sq_a),
    .sq_b      (sq_b)
  );

  pfc_pair_map #(.SIDE(SIDE)) u_pair_map (
    .mode   (mode_r),
    .pos_a  (pos_a),
    .pos_b  (pos_b),
    .cell_a (cell_a),
    .cell_b (cell_b)
  );

  assign out_valid       = out_valid_r;
  assign out_first_byte  = out_first_r;
  assign out_first_kept  = out_first_kept_r;
  assign out_second_byte = out_second_r;
  assign out_second_kept = out_second_kept_r;
  assign out_end_of_text = out_eot_r;

endmodule

`default_nettype wire
